// File: rtl/ofl_pkg.sv
package ofl_pkg;

  localparam int unsigned CoordW     = 32;
  localparam int unsigned CurW       = 34;
  localparam int unsigned OutW       = 38;
  localparam int unsigned CfgIdxW    = 1;
  localparam int unsigned QueueDepth = 2;

  localparam logic [2:0] SegLastStep = 3'd4;

  typedef enum logic [1:0] {
    OP_START  = 2'd0,
    OP_LINE   = 2'd1,
    OP_SPLINE = 2'd2,
    OP_CLOSE  = 2'd3
  } op_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_ORIGIN_X = 1'b0,
    CFG_ORIGIN_Y = 1'b1
  } cfg_idx_e;

  // one unit of work for the back end: a single point or a quadratic segment
  typedef struct packed {
    logic                     is_seg;
    logic                     first;
    logic                     last;
    logic signed [CurW-1:0]   a_x;
    logic signed [CurW-1:0]   a_y;
    logic signed [CoordW-1:0] b_x;
    logic signed [CoordW-1:0] b_y;
    logic signed [CurW-1:0]   c_x;
    logic signed [CurW-1:0]   c_y;
  } job_t;

  typedef struct packed {
    logic [4:0] wa;
    logic [4:0] wb;
    logic [4:0] wc;
  } weight_t;

  // bernstein weights at t = k/4, scaled by 16, with the 2x factor of the control point
  function automatic weight_t step_weights(logic [2:0] k, logic is_seg);
    weight_t w;
    w = '{wa: 5'd16, wb: 5'd0, wc: 5'd0};
    if (is_seg) begin
      case (k)
        3'd0: w = '{wa: 5'd16, wb: 5'd0,  wc: 5'd0};
        3'd1: w = '{wa: 5'd9,  wb: 5'd12, wc: 5'd1};
        3'd2: w = '{wa: 5'd4,  wb: 5'd16, wc: 5'd4};
        3'd3: w = '{wa: 5'd1,  wb: 5'd12, wc: 5'd9};
        3'd4: w = '{wa: 5'd0,  wb: 5'd0,  wc: 5'd16};
        default: w = '{wa: 5'd0, wb: 5'd0, wc: 5'd0};
      endcase
    end
    return w;
  endfunction

endpackage

// File: rtl/ofl_if.sv
interface ofl_in_if;
  import ofl_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [1:0]               opcode;
  logic signed [CoordW-1:0] pt_x;
  logic signed [CoordW-1:0] pt_y;
  logic                     record_end;

  modport source (output valid, output opcode, output pt_x, output pt_y,
                  output record_end, input ready);
  modport sink (input valid, input opcode, input pt_x, input pt_y,
                input record_end, output ready);
endinterface

interface ofl_out_if;
  import ofl_pkg::*;
  logic                   valid;
  logic                   ready;
  logic signed [OutW-1:0] out_x;
  logic signed [OutW-1:0] out_y;
  logic                   contour_first;
  logic                   contour_last;
  logic                   run_last;

  modport source (output valid, output out_x, output out_y, output contour_first,
                  output contour_last, output run_last, input ready);
  modport sink (input valid, input out_x, input out_y, input contour_first,
                input contour_last, input run_last, output ready);
endinterface

// File: rtl/ofl_queue.sv
module ofl_queue import ofl_pkg::*; #(
  parameter int unsigned Depth = QueueDepth
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t job_i,
  output logic full_o,
  input  logic pop_i,
  output job_t job_o,
  output logic empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  job_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign job_o   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

endmodule

// File: rtl/ofl_front.sv
module ofl_front import ofl_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  ofl_in_if.sink     in_i,
  input  logic       full_i,
  output logic       push_o,
  output job_t       job_o
);

  logic signed [CurW-1:0]   cur_x_q, cur_x_d, cur_y_q, cur_y_d;
  logic signed [CoordW-1:0] pend_x_q, pend_x_d, pend_y_q, pend_y_d;
  logic signed [CoordW-1:0] start_x_q, start_x_d, start_y_q, start_y_d;
  logic                     pend_vld_q, pend_vld_d;
  logic signed [CurW-1:0]   px2, py2, sx2, sy2, mid_x, mid_y;
  logic                     accept;

  assign in_i.ready = !full_i;
  assign accept     = in_i.valid && !full_i;
  assign push_o     = accept;

  // points in 2^-17 units
  assign px2   = {in_i.pt_x[CoordW-1], in_i.pt_x, 1'b0};
  assign py2   = {in_i.pt_y[CoordW-1], in_i.pt_y, 1'b0};
  assign sx2   = {start_x_q[CoordW-1], start_x_q, 1'b0};
  assign sy2   = {start_y_q[CoordW-1], start_y_q, 1'b0};
  assign mid_x = {{2{pend_x_q[CoordW-1]}}, pend_x_q} + {{2{in_i.pt_x[CoordW-1]}}, in_i.pt_x};
  assign mid_y = {{2{pend_y_q[CoordW-1]}}, pend_y_q} + {{2{in_i.pt_y[CoordW-1]}}, in_i.pt_y};

  always_comb begin
    cur_x_d    = cur_x_q;
    cur_y_d    = cur_y_q;
    pend_x_d   = pend_x_q;
    pend_y_d   = pend_y_q;
    start_x_d  = start_x_q;
    start_y_d  = start_y_q;
    pend_vld_d = pend_vld_q;
    job_o      = '{is_seg: 1'b0, first: 1'b0, last: 1'b0, a_x: px2, a_y: py2,
                   b_x: pend_x_q, b_y: pend_y_q, c_x: px2, c_y: py2};
    case (op_e'(in_i.opcode))
      OP_START: begin
        job_o.first = 1'b1;
        start_x_d   = in_i.pt_x;
        start_y_d   = in_i.pt_y;
        cur_x_d     = px2;
        cur_y_d     = py2;
        pend_vld_d  = 1'b0;
      end
      OP_CLOSE: begin
        job_o.last = 1'b1;
        job_o.a_x  = sx2;
        job_o.a_y  = sy2;
        pend_vld_d = 1'b0;
      end
      OP_LINE: begin
        cur_x_d    = px2;
        cur_y_d    = py2;
        pend_vld_d = 1'b0;
      end
      default: begin
        if (!pend_vld_q && in_i.record_end) begin
          // record end with nothing held acts as a line point
          cur_x_d = px2;
          cur_y_d = py2;
        end else if (!pend_vld_q) begin
          job_o.a_x  = cur_x_q;
          job_o.a_y  = cur_y_q;
          pend_x_d   = in_i.pt_x;
          pend_y_d   = in_i.pt_y;
          pend_vld_d = 1'b1;
        end else begin
          job_o.is_seg = 1'b1;
          job_o.a_x    = cur_x_q;
          job_o.a_y    = cur_y_q;
          if (in_i.record_end) begin
            cur_x_d    = px2;
            cur_y_d    = py2;
            pend_vld_d = 1'b0;
          end else begin
            job_o.c_x = mid_x;
            job_o.c_y = mid_y;
            cur_x_d   = mid_x;
            cur_y_d   = mid_y;
            pend_x_d  = in_i.pt_x;
            pend_y_d  = in_i.pt_y;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_x_q    <= '0;
      cur_y_q    <= '0;
      pend_x_q   <= '0;
      pend_y_q   <= '0;
      start_x_q  <= '0;
      start_y_q  <= '0;
      pend_vld_q <= 1'b0;
    end else if (accept) begin
      cur_x_q    <= cur_x_d;
      cur_y_q    <= cur_y_d;
      pend_x_q   <= pend_x_d;
      pend_y_q   <= pend_y_d;
      start_x_q  <= start_x_d;
      start_y_q  <= start_y_d;
      pend_vld_q <= pend_vld_d;
    end
  end

endmodule

// File: rtl/ofl_back.sv
module ofl_back import ofl_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CoordW-1:0]  cfg_data_i,
  input  logic               empty_i,
  input  job_t               job_i,
  output logic               pop_o,
  ofl_out_if.source          out_o
);

  logic signed [CoordW-1:0] org_x_q, org_y_q;
  logic [2:0]               k_q, k_d;
  logic                     out_vld_q, out_vld_d;
  logic signed [OutW-1:0]   out_x_q, out_y_q, x_d, y_d;
  logic                     first_q, last_q, run_last_q, step_last;
  logic                     fire;
  weight_t                  w;

  function automatic logic signed [OutW-1:0] eval_pt(
    logic signed [CurW-1:0] a, logic signed [CoordW-1:0] b,
    logic signed [CurW-1:0] c, logic signed [CoordW-1:0] org, weight_t wt);
    logic signed [OutW-1:0] a38, b38, c38, o38;
    a38 = {{(OutW-CurW){a[CurW-1]}}, a};
    b38 = {{(OutW-CoordW){b[CoordW-1]}}, b};
    c38 = {{(OutW-CurW){c[CurW-1]}}, c};
    o38 = {org[CoordW-1], org, 5'b0};
    return OutW'(a38 * $signed({1'b0, wt.wa})) + OutW'(b38 * $signed({1'b0, wt.wb}))
         + OutW'(c38 * $signed({1'b0, wt.wc})) + o38;
  endfunction

  assign w         = step_weights(k_q, job_i.is_seg);
  assign fire      = !empty_i && (!out_vld_q || out_o.ready);
  assign step_last = !job_i.is_seg || (k_q == SegLastStep);
  assign pop_o     = fire && step_last;
  assign x_d       = eval_pt(job_i.a_x, job_i.b_x, job_i.c_x, org_x_q, w);
  assign y_d       = eval_pt(job_i.a_y, job_i.b_y, job_i.c_y, org_y_q, w);

  always_comb begin
    k_d       = k_q;
    out_vld_d = out_vld_q;
    if (out_o.ready) begin
      out_vld_d = 1'b0;
    end
    if (fire) begin
      out_vld_d = 1'b1;
      k_d       = step_last ? 3'd0 : k_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      org_x_q   <= '0;
      org_y_q   <= '0;
      k_q       <= '0;
      out_vld_q <= 1'b0;
    end else begin
      k_q       <= k_d;
      out_vld_q <= out_vld_d;
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_ORIGIN_X: org_x_q <= cfg_data_i;
          CFG_ORIGIN_Y: org_y_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_x_q    <= x_d;
      out_y_q    <= y_d;
      first_q    <= job_i.first;
      last_q     <= job_i.last;
      run_last_q <= step_last;
    end
  end

  assign out_o.valid         = out_vld_q;
  assign out_o.out_x         = out_x_q;
  assign out_o.out_y         = out_y_q;
  assign out_o.contour_first = first_q;
  assign out_o.contour_last  = last_q;
  assign out_o.run_last      = run_last_q;

endmodule

// File: rtl/glyph_outline_flattener.sv
// channel   dir  payload                                             handshake
// in_i      in   opcode, pt_x, pt_y, record_end                      valid/ready
// out_o     out  out_x, out_y, contour_first, contour_last, run_last valid/ready
// cfg       in   cfg_idx_i, cfg_data_i                               cfg_we_i
//
// start, line, close and first control point: one result each
// a spline segment: five results, one a cycle from the shared evaluator while out_o is not stalled
// requests wait in the job queue, then pass through the evaluator into the result register
// reset is asynchronous, active low, and clears pen origin and outline state to zero
// out_o stalls hold the result register; input stalls only when the job queue is full
module glyph_outline_flattener import ofl_pkg::*; #(
  parameter int unsigned QDepth = QueueDepth
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CoordW-1:0]  cfg_data_i,
  ofl_in_if.sink             in_i,
  ofl_out_if.source          out_o
);

  logic push, pop, full, empty;
  job_t job_in, job_out;

  ofl_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .full_i (full),
    .push_o (push),
    .job_o  (job_in)
  );

  ofl_queue #(.Depth(QDepth)) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (job_in),
    .full_o  (full),
    .pop_i   (pop),
    .job_o   (job_out),
    .empty_o (empty)
  );

  ofl_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .empty_i    (empty),
    .job_i      (job_out),
    .pop_o      (pop),
    .out_o      (out_o)
  );

endmodule

// File: rtl/ofl_checker.sv
module ofl_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic out_valid_i,
  input logic out_ready_i,
  input logic contour_first_i,
  input logic contour_last_i,
  input logic run_last_i
);

  // a result not yet taken stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  // start and close results are single-result requests
  a_first_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && contour_first_i |-> run_last_i)
    else $error("contour start result not last of its request");

  a_last_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && contour_last_i |-> run_last_i)
    else $error("contour close result not last of its request");

  a_flags_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> !(contour_first_i && contour_last_i))
    else $error("start and close flags together");

endmodule

bind glyph_outline_flattener ofl_checker u_ofl_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_i     (out_o.valid),
  .out_ready_i     (out_o.ready),
  .contour_first_i (out_o.contour_first),
  .contour_last_i  (out_o.contour_last),
  .run_last_i      (out_o.run_last)
);

// File: tb/sv/outline_point_checker.sv
`timescale 1ns / 1ps

module outline_point_checker import ofl_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CoordW-1:0]  cfg_data_i,
  ofl_in_if                  in_mon_i,
  ofl_out_if                 out_mon_i,
  output int                 mismatches_o,
  output int                 outstanding_o
);

  typedef struct {
    logic signed [OutW-1:0] x;
    logic signed [OutW-1:0] y;
    logic                   first;
    logic                   last;
    logic                   run_last;
  } flat_point_t;

  flat_point_t expected_points[$];
  flat_point_t due;
  int          mismatches;

  logic signed [CoordW-1:0] pen_x, pen_y;
  logic signed [CurW-1:0]   cur_x, cur_y;
  logic signed [CoordW-1:0] held_x, held_y;
  logic                     held_valid;
  logic signed [CoordW-1:0] home_x, home_y;

  // quadratic bezier at t = k/4, a and c in 2^-17 units, b in 16.16, result in 2^-21
  function automatic longint spline_at(longint a17, longint b16, longint c17, int k);
    return a17 * (4 - k) * (4 - k) + 4 * b16 * k * (4 - k) + c17 * k * k;
  endfunction

  task automatic add_point(longint px21, longint py21, bit first, bit last, bit run_end);
    flat_point_t p;
    longint      sx, sy;
    sx = px21 + longint'(pen_x) * 32;
    sy = py21 + longint'(pen_y) * 32;
    p.x        = sx[OutW-1:0];
    p.y        = sy[OutW-1:0];
    p.first    = first;
    p.last     = last;
    p.run_last = run_end;
    expected_points.push_back(p);
  endtask

  task automatic emit_segment(longint cx17, longint cy17);
    for (int k = 0; k < 5; k++) begin
      add_point(spline_at(longint'(cur_x), longint'(held_x), cx17, k),
                spline_at(longint'(cur_y), longint'(held_y), cy17, k), 1'b0, 1'b0, k == 4);
    end
    cur_x = cx17[CurW-1:0];
    cur_y = cy17[CurW-1:0];
  endtask

  task automatic flatten_request(op_e op, logic signed [CoordW-1:0] x,
                                 logic signed [CoordW-1:0] y, logic rend);
    longint x32, y32;
    x32 = longint'(x);
    y32 = longint'(y);
    case (op)
      OP_START: begin
        home_x     = x;
        home_y     = y;
        cur_x      = CurW'(x32 * 2);
        cur_y      = CurW'(y32 * 2);
        held_valid = 1'b0;
        add_point(x32 * 32, y32 * 32, 1'b1, 1'b0, 1'b1);
      end
      OP_CLOSE: begin
        held_valid = 1'b0;
        add_point(longint'(home_x) * 32, longint'(home_y) * 32, 1'b0, 1'b1, 1'b1);
      end
      default: begin
        if (op == OP_LINE || (rend && !held_valid)) begin
          held_valid = 1'b0;
          cur_x      = CurW'(x32 * 2);
          cur_y      = CurW'(y32 * 2);
          add_point(x32 * 32, y32 * 32, 1'b0, 1'b0, 1'b1);
        end else if (!held_valid) begin
          add_point(longint'(cur_x) * 16, longint'(cur_y) * 16, 1'b0, 1'b0, 1'b1);
          held_x     = x;
          held_y     = y;
          held_valid = 1'b1;
        end else if (!rend) begin
          // implied on-curve midpoint between two control points
          emit_segment(longint'(held_x) + x32, longint'(held_y) + y32);
          held_x = x;
          held_y = y;
        end else begin
          emit_segment(x32 * 2, y32 * 2);
          held_valid = 1'b0;
        end
      end
    endcase
  endtask

  task automatic compare_field(string name, logic signed [63:0] want,
                               logic signed [63:0] seen);
    if (want !== seen) begin
      $error("%s expected %0d actual %0d", name, want, seen);
      mismatches++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pen_x      = '0;
      pen_y      = '0;
      cur_x      = '0;
      cur_y      = '0;
      held_x     = '0;
      held_y     = '0;
      held_valid = 1'b0;
      home_x     = '0;
      home_y     = '0;
      mismatches = 0;
      expected_points.delete();
      mismatches_o  <= 0;
      outstanding_o <= 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_e'(cfg_idx_i) == CFG_ORIGIN_X) begin
          pen_x = cfg_data_i;
        end else begin
          pen_y = cfg_data_i;
        end
      end
      if (out_mon_i.valid && out_mon_i.ready) begin
        if (expected_points.size() == 0) begin
          $error("unexpected result out_x %0d out_y %0d", out_mon_i.out_x, out_mon_i.out_y);
          mismatches++;
        end else begin
          due = expected_points.pop_front();
          compare_field("out_x", due.x, out_mon_i.out_x);
          compare_field("out_y", due.y, out_mon_i.out_y);
          compare_field("contour_first", due.first, out_mon_i.contour_first);
          compare_field("contour_last", due.last, out_mon_i.contour_last);
          compare_field("run_last", due.run_last, out_mon_i.run_last);
        end
      end
      if (in_mon_i.valid && in_mon_i.ready) begin
        flatten_request(op_e'(in_mon_i.opcode), in_mon_i.pt_x, in_mon_i.pt_y,
                        in_mon_i.record_end);
      end
      mismatches_o  <= mismatches;
      outstanding_o <= expected_points.size();
    end
  end

endmodule

// File: tb/sv/tb_glyph_outline_flattener.sv
`timescale 1ns / 1ps

module tb_glyph_outline_flattener import ofl_pkg::*; ();

  localparam int HoldCycles = 300;
  localparam int StallLimit = 3000;
  localparam int PhaseItems = 160;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               cfg_we;
  logic [CfgIdxW-1:0] cfg_idx;
  logic [CoordW-1:0]  cfg_data;
  int                 mismatches;
  int                 outstanding;

  int tx_idle = 0;
  int rx_idle = 0;
  int sent = 0;
  int hold_reqs = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int quiet_cycles = 0;

  ofl_in_if  in_if ();
  ofl_out_if out_if ();

  glyph_outline_flattener u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  outline_point_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_data_i    (cfg_data),
    .in_mon_i      (in_if),
    .out_mon_i     (out_if),
    .mismatches_o  (mismatches),
    .outstanding_o (outstanding)
  );

  always #5 clk_i = ~clk_i;

  // result side: random stalls, plus a long hold-off on request
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      out_if.ready <= 1'b0;
      hold_left    <= hold_left - 1;
    end else if (hold_seen != hold_reqs) begin
      out_if.ready <= 1'b0;
      hold_seen    <= hold_reqs;
      hold_left    <= HoldCycles;
    end else begin
      out_if.ready <= ($urandom_range(99) >= rx_idle);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= StallLimit) begin
        $display("tb_glyph_outline_flattener: FAIL");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  function automatic logic [CoordW-1:0] pick_coord();
    case ($urandom_range(9))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return $urandom_range(1) ? 32'h0 : 32'hffff_ffff;
      3, 4, 5: return CoordW'($signed($urandom_range(32'h0020_0000)) - 32'sh0010_0000);
      default: return $urandom;
    endcase
  endfunction

  task automatic offer(op_e op, logic [CoordW-1:0] x, logic [CoordW-1:0] y, logic rend);
    while ($urandom_range(99) < tx_idle) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid      <= 1'b1;
    in_if.opcode     <= op;
    in_if.pt_x       <= x;
    in_if.pt_y       <= y;
    in_if.record_end <= rend;
    do @(posedge clk_i); while (!in_if.ready);
    sent++;
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic set_origin(logic [CoordW-1:0] x, logic [CoordW-1:0] y);
    cfg_we   <= 1'b1;
    cfg_idx  <= CFG_ORIGIN_X;
    cfg_data <= x;
    @(posedge clk_i);
    cfg_idx  <= CFG_ORIGIN_Y;
    cfg_data <= y;
    @(posedge clk_i);
    cfg_we   <= 1'b0;
  endtask

  task automatic send_contour();
    int records;
    int ctrl;
    offer(OP_START, pick_coord(), pick_coord(), 1'($urandom_range(1)));
    records = $urandom_range(1, 5);
    repeat (records) begin
      if ($urandom_range(2) == 0) begin
        offer(OP_LINE, pick_coord(), pick_coord(), 1'($urandom_range(1)));
      end else begin
        ctrl = $urandom_range(1, 4);
        repeat (ctrl) offer(OP_SPLINE, pick_coord(), pick_coord(), 1'b0);
        offer(OP_SPLINE, pick_coord(), pick_coord(), 1'b1);
      end
    end
    if ($urandom_range(9) != 0) begin
      offer(OP_CLOSE, pick_coord(), pick_coord(), 1'($urandom_range(1)));
    end
  endtask

  task automatic send_phase(int goal);
    int burst;
    goal = sent + goal;
    while (sent < goal) begin
      if ($urandom_range(4) != 0) begin
        send_contour();
      end else begin
        burst = $urandom_range(1, 3);
        repeat (burst) begin
          offer(op_e'($urandom_range(3)), pick_coord(), pick_coord(),
                1'($urandom_range(1)));
        end
      end
    end
  endtask

  initial begin
    rst_ni           = 1'b0;
    cfg_we           = 1'b0;
    cfg_idx          = CFG_ORIGIN_X;
    cfg_data         = '0;
    in_if.valid      = 1'b0;
    in_if.opcode     = OP_START;
    in_if.pt_x       = '0;
    in_if.pt_y       = '0;
    in_if.record_end = 1'b0;
    out_if.ready     = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    tx_idle = 36;
    rx_idle = 81;
    // spline before any contour start works from the reset point
    offer(OP_SPLINE, 32'h7fff_ffff, 32'h8000_0000, 1'b0);
    offer(OP_SPLINE, 32'h8000_0000, 32'h7fff_ffff, 1'b1);
    offer(OP_START, 32'h7fff_ffff, 32'h8000_0000, 1'b0);
    offer(OP_LINE, 32'h8000_0000, 32'h7fff_ffff, 1'b1);
    offer(OP_LINE, 32'hffff_ffff, 32'h0000_0001, 1'b0);
    offer(OP_SPLINE, 32'h1234_5678, 32'hedcb_a987, 1'b0);
    offer(OP_SPLINE, 32'h7fff_ffff, 32'h7fff_ffff, 1'b0);
    offer(OP_SPLINE, 32'h8000_0000, 32'h8000_0000, 1'b0);
    offer(OP_SPLINE, 32'h0000_0000, 32'hffff_ffff, 1'b1);
    offer(OP_SPLINE, 32'h0001_8000, 32'hfffe_8000, 1'b1);
    offer(OP_SPLINE, 32'h0003_0000, 32'h0004_0000, 1'b0);
    offer(OP_CLOSE, 32'hdead_beef, 32'h5a5a_a5a5, 1'b1);
    offer(OP_SPLINE, 32'h0005_0000, 32'h0006_0000, 1'b1);
    offer(OP_SPLINE, 32'h8000_0000, 32'h7fff_ffff, 1'b0);
    offer(OP_LINE, 32'h0000_0000, 32'h0000_0000, 1'b0);
    offer(OP_SPLINE, 32'h7fff_ffff, 32'h8000_0000, 1'b0);
    offer(OP_START, 32'h0000_0000, 32'hffff_ffff, 1'b1);
    offer(OP_SPLINE, 32'h7fff_ffff, 32'h7fff_ffff, 1'b1);
    offer(OP_CLOSE, 32'h0000_0000, 32'h0000_0000, 1'b0);
    offer(OP_CLOSE, 32'hffff_ffff, 32'hffff_ffff, 1'b1);
    drain();

    set_origin(32'h7fff_ffff, 32'h8000_0000);
    send_phase(PhaseItems);
    drain();

    tx_idle = 81;
    rx_idle = 36;
    set_origin($urandom, $urandom);
    send_phase(PhaseItems);
    drain();

    tx_idle = 0;
    rx_idle = 0;
    set_origin(32'h8000_0000, 32'h7fff_ffff);
    hold_reqs++;
    send_phase(PhaseItems);
    drain();

    if (mismatches == 0 && outstanding == 0) begin
      $display("tb_glyph_outline_flattener: PASS");
    end else begin
      $display("tb_glyph_outline_flattener: FAIL");
    end
    $finish;
  end

endmodule
